### rtl/sparse_table_range_min_defines.svh
// Assertion macros used by the range-minimum sequencer (stm_seq).
// Both macros sample on i_clk and are quiet while i_rst_n is low.
`ifndef SPARSE_TABLE_RANGE_MIN_DEFINES_SVH
`define SPARSE_TABLE_RANGE_MIN_DEFINES_SVH

`ifndef SYNTHESIS

// Same-cycle implication
`define STM_ASSERT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication
`define STM_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`else

`define STM_ASSERT(lbl, ante, cons, msg)
`define STM_ASSERT_NEXT(lbl, ante, cons, msg)

`endif

`endif

### rtl/stm_pkg.sv
`default_nettype none

package stm_pkg;

    // Field widths of the request and result
    localparam int ACTION_W = 2;
    localparam int VALUE_W  = 32;
    localparam int INDEX_W  = 10;
    localparam int STATUS_W = 2;
    localparam int COUNT_W  = 11;

    // Packed stream widths
    localparam int S_TDATA_W = 56;  // value, left_index, right_index, zero pad
    localparam int M_TDATA_W = 48;  // min_value, count, zero pad

    // Action codes
    localparam logic [ACTION_W-1:0] ACT_CLEAR  = 2'd0;
    localparam logic [ACTION_W-1:0] ACT_APPEND = 2'd1;
    localparam logic [ACTION_W-1:0] ACT_QUERY  = 2'd2;

    // Status codes
    localparam logic [STATUS_W-1:0] STAT_OK        = 2'd0;
    localparam logic [STATUS_W-1:0] STAT_BAD_RANGE = 2'd1;
    localparam logic [STATUS_W-1:0] STAT_FULL      = 2'd2;

    typedef struct packed {
        logic signed [VALUE_W-1:0] min_value;
        logic [STATUS_W-1:0]       status;
        logic [COUNT_W-1:0]        count;
    } t_result;

endpackage

`default_nettype wire

### rtl/sparse_table_range_min.sv
// Range-minimum engine built on a sparse table held in one synchronous RAM.
// Slave stream: tuser carries the action (clear, append, query); tdata carries
// value, left_index and right_index. Master stream: one result per request,
// tdata carries min_value and count, tuser carries the status.
// Clear, an unused action, a full append and a bad range go straight to the result.
// A query makes two RAM reads through the single read port, then compares.
// An append walks levels 1 to L, L = min(floor(log2(new count)), LEVELS-1);
// each level takes one RAM read and one write of the combined minimum.
// One request is in work at a time; the next is taken once its result has
// moved into the output register.
// Reset clears the element count and the control state; the RAM is not
// cleared, entries are only read after an append has written them.
// A stalled master holds the result in the output register; the sequencer
// finishes the next request and then waits until that register is free.
`default_nettype none

module sparse_table_range_min #(
    parameter int MAX_ELEMENTS = 1024,
    parameter int LEVELS       = 11
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_s_tvalid,
    output logic                               o_s_tready,
    // value[31:0], left_index[41:32], right_index[51:42], zero[55:52]
    input  wire logic [stm_pkg::S_TDATA_W-1:0] i_s_tdata,
    // action[1:0]
    input  wire logic [stm_pkg::ACTION_W-1:0]  i_s_tuser,
    output logic                               o_m_tvalid,
    input  wire logic                          i_m_tready,
    // min_value[31:0], count[42:32], zero[47:43]
    output logic [stm_pkg::M_TDATA_W-1:0]      o_m_tdata,
    // status[1:0]
    output logic [stm_pkg::STATUS_W-1:0]       o_m_tuser
);
    import stm_pkg::*;

    localparam int IDX_W  = $clog2(MAX_ELEMENTS);
    localparam int DEPTH  = LEVELS << IDX_W;
    localparam int ADDR_W = $clog2(DEPTH);

    logic                      mem_we;
    logic [ADDR_W-1:0]         mem_waddr;
    logic signed [VALUE_W-1:0] mem_wdata;
    logic                      mem_re;
    logic [ADDR_W-1:0]         mem_raddr;
    logic signed [VALUE_W-1:0] mem_rdata;
    logic                      res_valid;
    logic                      res_ready;
    t_result                   res;

    // Request field unpacking
    logic signed [VALUE_W-1:0] s_value;
    logic [INDEX_W-1:0]        s_left;
    logic [INDEX_W-1:0]        s_right;

    assign s_value = i_s_tdata[VALUE_W-1:0];
    assign s_left  = i_s_tdata[VALUE_W +: INDEX_W];
    assign s_right = i_s_tdata[VALUE_W+INDEX_W +: INDEX_W];

    stm_seq #(
        .MAX_ELEMENTS (MAX_ELEMENTS),
        .LEVELS       (LEVELS),
        .ADDR_W       (ADDR_W)
    ) u_seq (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_req_valid   (i_s_tvalid),
        .o_req_ready   (o_s_tready),
        .i_action      (i_s_tuser),
        .i_value       (s_value),
        .i_left_index  (s_left),
        .i_right_index (s_right),
        .o_mem_we      (mem_we),
        .o_mem_waddr   (mem_waddr),
        .o_mem_wdata   (mem_wdata),
        .o_mem_re      (mem_re),
        .o_mem_raddr   (mem_raddr),
        .i_mem_rdata   (mem_rdata),
        .o_res_valid   (res_valid),
        .i_res_ready   (res_ready),
        .o_res         (res)
    );

    stm_ram #(
        .DEPTH  (DEPTH),
        .ADDR_W (ADDR_W)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (mem_waddr),
        .i_wdata (mem_wdata),
        .i_re    (mem_re),
        .i_raddr (mem_raddr),
        .o_rdata (mem_rdata)
    );

    stm_obuf u_obuf (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_res_valid (res_valid),
        .o_res_ready (res_ready),
        .i_res       (res),
        .o_m_tvalid  (o_m_tvalid),
        .i_m_tready  (i_m_tready),
        .o_m_tdata   (o_m_tdata),
        .o_m_tuser   (o_m_tuser)
    );

endmodule

`default_nettype wire

### rtl/stm_ram.sv
`default_nettype none

// Simple dual-port table memory: one write, one registered read per cycle
module stm_ram #(
    parameter int DEPTH  = 11264,
    parameter int ADDR_W = 14
) (
    input  wire logic                               i_clk,
    input  wire logic                               i_we,
    input  wire logic [ADDR_W-1:0]                  i_waddr,
    input  wire logic signed [stm_pkg::VALUE_W-1:0] i_wdata,
    input  wire logic                               i_re,
    input  wire logic [ADDR_W-1:0]                  i_raddr,
    output logic signed [stm_pkg::VALUE_W-1:0]      o_rdata
);
    import stm_pkg::*;

    logic signed [VALUE_W-1:0] r_mem [DEPTH];
    logic signed [VALUE_W-1:0] r_rdata;

    // Write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Read port, registered
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

### rtl/stm_seq.sv
`default_nettype none

// Request sequencer: decodes the action, walks the table levels on append,
// reads the two overlapping spans on query, and hands one result downstream.
module stm_seq #(
    parameter int MAX_ELEMENTS = 1024,
    parameter int LEVELS       = 11,
    parameter int ADDR_W       = 14
) (
    input  wire logic                               i_clk,
    input  wire logic                               i_rst_n,
    // request side
    input  wire logic                               i_req_valid,
    output logic                                    o_req_ready,
    input  wire logic [stm_pkg::ACTION_W-1:0]       i_action,
    input  wire logic signed [stm_pkg::VALUE_W-1:0] i_value,
    input  wire logic [stm_pkg::INDEX_W-1:0]        i_left_index,
    input  wire logic [stm_pkg::INDEX_W-1:0]        i_right_index,
    // table memory
    output logic                                    o_mem_we,
    output logic [ADDR_W-1:0]                       o_mem_waddr,
    output logic signed [stm_pkg::VALUE_W-1:0]      o_mem_wdata,
    output logic                                    o_mem_re,
    output logic [ADDR_W-1:0]                       o_mem_raddr,
    input  wire logic signed [stm_pkg::VALUE_W-1:0] i_mem_rdata,
    // result side
    output logic                                    o_res_valid,
    input  wire logic                               i_res_ready,
    output stm_pkg::t_result                        o_res
);
    import stm_pkg::*;

    localparam int IDX_W = $clog2(MAX_ELEMENTS);
    localparam int CNT_W = $clog2(MAX_ELEMENTS + 1);
    localparam int LVL_W = $clog2(LEVELS);
    localparam int LOG_W = $clog2(CNT_W);
    localparam int CMP_W = (CNT_W > INDEX_W) ? CNT_W : INDEX_W;

    typedef enum logic [2:0] {
        S_IDLE,
        S_APP_RD,
        S_APP_WR,
        S_Q_RD0,
        S_Q_RD1,
        S_Q_MIN,
        S_DONE
    } t_state;

    // Position of the highest set bit
    function automatic logic [LOG_W-1:0] flog2(input logic [CNT_W-1:0] x);
        logic [LOG_W-1:0] r;
        r = '0;
        for (int i = 0; i < CNT_W; i++) begin
            if (x[i]) begin
                r = LOG_W'(i);
            end
        end
        return r;
    endfunction

    // Level clamp to the top of the table
    function automatic logic [LVL_W-1:0] clamp_lvl(input logic [LOG_W-1:0] p);
        logic [LVL_W-1:0] r;
        if (int'(p) > LEVELS - 1) begin
            r = LVL_W'(LEVELS - 1);
        end else begin
            r = LVL_W'(p);
        end
        return r;
    endfunction

    t_state                   r_state;
    logic [CNT_W-1:0]         r_count;
    logic [IDX_W-1:0]         r_idx;      // append index, or query left index
    logic [IDX_W-1:0]         r_second;   // query start of right span
    logic [LVL_W-1:0]         r_lvl;
    logic [LVL_W-1:0]         r_top;
    logic signed [VALUE_W-1:0] r_prev;    // span just written one level down
    logic signed [VALUE_W-1:0] r_first;
    t_result                  r_res;

    logic                     req_acc;
    logic                     full;
    logic                     bad_range;
    logic [IDX_W-1:0]         cnt_idx;
    logic [CNT_W-1:0]         cnt_inc;
    logic [LVL_W-1:0]         app_top;
    logic [INDEX_W:0]         q_len;
    logic [LVL_W-1:0]         q_lvl;
    logic [IDX_W-1:0]         hi_idx;
    logic [IDX_W:0]           q_second;
    logic [IDX_W:0]           app_start;
    logic signed [VALUE_W-1:0] app_min;
    logic signed [VALUE_W-1:0] q_min;

    assign req_acc  = i_req_valid && o_req_ready;
    assign full     = (r_count == CNT_W'(MAX_ELEMENTS));
    assign cnt_idx  = IDX_W'(r_count);
    assign cnt_inc  = r_count + CNT_W'(1);
    assign app_top  = clamp_lvl(flog2(cnt_inc));

    // Query range check and span level
    assign bad_range = (i_left_index > i_right_index) ||
                       (CMP_W'(i_right_index) >= CMP_W'(r_count));
    assign q_len     = {1'b0, i_right_index} - {1'b0, i_left_index} + (INDEX_W+1)'(1);
    assign q_lvl     = clamp_lvl(flog2(CNT_W'(q_len)));
    assign hi_idx    = IDX_W'(i_right_index);
    assign q_second  = {1'b0, hi_idx} + (IDX_W+1)'(1) - ((IDX_W+1)'(1) << q_lvl);

    // Start of the span at the current level that ends at the new index
    assign app_start = {1'b0, r_idx} + (IDX_W+1)'(1) - ((IDX_W+1)'(1) << r_lvl);

    assign app_min = (i_mem_rdata < r_prev) ? i_mem_rdata : r_prev;
    assign q_min   = (i_mem_rdata < r_first) ? i_mem_rdata : r_first;

    // Memory access per state
    always_comb begin
        o_mem_we    = 1'b0;
        o_mem_waddr = '0;
        o_mem_wdata = i_value;
        o_mem_re    = 1'b0;
        o_mem_raddr = '0;
        case (r_state)
            S_IDLE: begin
                o_mem_we    = req_acc && (i_action == ACT_APPEND) && !full;
                o_mem_waddr = {LVL_W'(0), cnt_idx};
                o_mem_wdata = i_value;
            end
            S_APP_RD: begin
                o_mem_re    = 1'b1;
                o_mem_raddr = {r_lvl - LVL_W'(1), app_start[IDX_W-1:0]};
            end
            S_APP_WR: begin
                o_mem_we    = 1'b1;
                o_mem_waddr = {r_lvl, app_start[IDX_W-1:0]};
                o_mem_wdata = app_min;
            end
            S_Q_RD0: begin
                o_mem_re    = 1'b1;
                o_mem_raddr = {r_lvl, r_idx};
            end
            S_Q_RD1: begin
                o_mem_re    = 1'b1;
                o_mem_raddr = {r_lvl, r_second};
            end
            default: begin
            end
        endcase
    end

    // State, count and result registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_count <= '0;
        end else begin
            case (r_state)
                S_IDLE: begin
                    if (req_acc) begin
                        r_res.min_value <= '0;
                        case (i_action)
                            ACT_CLEAR: begin
                                r_count      <= '0;
                                r_res.status <= STAT_OK;
                                r_res.count  <= '0;
                                r_state      <= S_DONE;
                            end
                            ACT_APPEND: begin
                                if (full) begin
                                    r_res.status <= STAT_FULL;
                                    r_res.count  <= COUNT_W'(r_count);
                                    r_state      <= S_DONE;
                                end else begin
                                    r_res.status <= STAT_OK;
                                    r_count      <= cnt_inc;
                                    r_res.count  <= COUNT_W'(cnt_inc);
                                    r_idx        <= cnt_idx;
                                    r_prev       <= i_value;
                                    r_top        <= app_top;
                                    r_lvl        <= LVL_W'(1);
                                    // single element spans need no upper levels
                                    r_state      <= (app_top != '0) ? S_APP_RD : S_DONE;
                                end
                            end
                            ACT_QUERY: begin
                                r_res.count <= COUNT_W'(r_count);
                                if (bad_range) begin
                                    r_res.status <= STAT_BAD_RANGE;
                                    r_state      <= S_DONE;
                                end else begin
                                    r_res.status <= STAT_OK;
                                    r_idx        <= IDX_W'(i_left_index);
                                    r_second     <= q_second[IDX_W-1:0];
                                    r_lvl        <= q_lvl;
                                    r_state      <= S_Q_RD0;
                                end
                            end
                            default: begin
                                r_res.status <= STAT_OK;
                                r_res.count  <= COUNT_W'(r_count);
                                r_state      <= S_DONE;
                            end
                        endcase
                    end
                end
                S_APP_RD: begin
                    r_state <= S_APP_WR;
                end
                S_APP_WR: begin
                    r_prev <= app_min;
                    if (r_lvl == r_top) begin
                        r_state <= S_DONE;
                    end else begin
                        r_lvl   <= r_lvl + LVL_W'(1);
                        r_state <= S_APP_RD;
                    end
                end
                S_Q_RD0: begin
                    r_state <= S_Q_RD1;
                end
                S_Q_RD1: begin
                    r_first <= i_mem_rdata;
                    r_state <= S_Q_MIN;
                end
                S_Q_MIN: begin
                    r_res.min_value <= q_min;
                    r_state         <= S_DONE;
                end
                S_DONE: begin
                    if (i_res_ready) begin
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_req_ready = (r_state == S_IDLE);
    assign o_res_valid = (r_state == S_DONE);
    assign o_res       = r_res;

`include "sparse_table_range_min_defines.svh"

    `STM_ASSERT(a_no_rw_overlap, o_mem_re, !o_mem_we, "table read and write in one cycle")
    `STM_ASSERT(a_count_bound, 1'b1, r_count <= CNT_W'(MAX_ELEMENTS), "count above capacity")
    `STM_ASSERT(a_level_bound, r_state == S_APP_WR, (r_lvl != '0) && (r_lvl <= r_top), "append level outside span range")
    `STM_ASSERT(a_err_zero, (r_state == S_DONE) && (r_res.status != STAT_OK), r_res.min_value == '0, "error result with nonzero minimum")
    `STM_ASSERT_NEXT(a_query_reads, (r_state == S_Q_RD0), (r_state == S_Q_RD1) && o_mem_re, "query second span not read")

endmodule

`default_nettype wire

### rtl/stm_obuf.sv
`default_nettype none

// Output register: holds one result for the master stream so the
// sequencer can take the next request while the result waits.
module stm_obuf (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire logic                         i_res_valid,
    output logic                              o_res_ready,
    input  wire stm_pkg::t_result             i_res,
    output logic                              o_m_tvalid,
    input  wire logic                         i_m_tready,
    output logic [stm_pkg::M_TDATA_W-1:0]     o_m_tdata,
    output logic [stm_pkg::STATUS_W-1:0]      o_m_tuser
);
    import stm_pkg::*;

    localparam int PAD_W = M_TDATA_W - VALUE_W - COUNT_W;

    logic    r_valid;
    t_result r_data;

    assign o_res_ready = !r_valid || i_m_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_res_ready) begin
            r_valid <= i_res_valid;
        end
    end

    // Payload, no reset
    always_ff @(posedge i_clk) begin
        if (o_res_ready && i_res_valid) begin
            r_data <= i_res;
        end
    end

    assign o_m_tvalid = r_valid;
    assign o_m_tdata  = {PAD_W'(0), r_data.count, r_data.min_value};
    assign o_m_tuser  = r_data.status;

endmodule

`default_nettype wire

### tb/sv/tb_sparse_table_range_min.sv
module tb_sparse_table_range_min;

    import stm_pkg::*;

    localparam int MAX_ELEMENTS = 1024;
    localparam int LEVELS       = 11;
    localparam int CLK_HALF     = 2;

    // Action code the block takes and answers without doing anything
    localparam logic [ACTION_W-1:0] ACT_UNUSED = 2'd3;

    localparam logic signed [VALUE_W-1:0] VALUE_MAX = 32'sh7FFF_FFFF;
    localparam logic signed [VALUE_W-1:0] VALUE_MIN = 32'sh8000_0000;
    localparam logic [INDEX_W-1:0]        INDEX_TOP = '1;

    logic                   i_clk       = 1'b0;
    logic                   i_rst_n     = 1'b0;
    logic                   i_s_tvalid  = 1'b0;
    logic                   o_s_tready;
    logic [S_TDATA_W-1:0]   i_s_tdata   = '0;
    logic [ACTION_W-1:0]    i_s_tuser   = '0;
    logic                   o_m_tvalid;
    logic                   i_m_tready  = 1'b0;
    logic [M_TDATA_W-1:0]   o_m_tdata;
    logic [STATUS_W-1:0]    o_m_tuser;

    // Local copy of the table contents and element count
    logic signed [VALUE_W-1:0] span_min [LEVELS][MAX_ELEMENTS];
    int unsigned               elem_count = 0;

    t_result pending_results [$];
    int      error_count   = 0;
    int      send_idle_pct = 0;
    int      stall_pct     = 0;

    sparse_table_range_min #(
        .MAX_ELEMENTS (MAX_ELEMENTS),
        .LEVELS       (LEVELS)
    ) u_top (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .i_s_tuser  (i_s_tuser),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata),
        .o_m_tuser  (o_m_tuser)
    );

    initial begin
        forever #CLK_HALF i_clk = ~i_clk;
    end

    // Hard stop in case the block hangs
    initial begin
        #4000000;
        $display("DONE: errors detected");
        $finish;
    end

    // Apply one request to the local table and return the answer it produces
    task automatic sparse_table_step(input logic [ACTION_W-1:0] act,
                                     input logic signed [VALUE_W-1:0] val,
                                     input logic [INDEX_W-1:0] lo,
                                     input logic [INDEX_W-1:0] hi,
                                     output t_result res);
        int unsigned idx;
        int unsigned lvl;
        int unsigned first;
        int unsigned len;
        logic signed [VALUE_W-1:0] a;
        logic signed [VALUE_W-1:0] b;
        res = '0;
        case (act)
            ACT_CLEAR: begin
                elem_count = 0;
            end
            ACT_APPEND: begin
                if (elem_count >= MAX_ELEMENTS) begin
                    res.status = STAT_FULL;
                end else begin
                    idx = elem_count;
                    span_min[0][idx] = val;
                    // fill every span that now ends at idx
                    for (lvl = 1; lvl < LEVELS && (1 << lvl) <= idx + 1; lvl++) begin
                        first = idx + 1 - (1 << lvl);
                        a = span_min[lvl-1][first];
                        b = span_min[lvl-1][first + (1 << (lvl - 1))];
                        span_min[lvl][first] = (a < b) ? a : b;
                    end
                    elem_count = idx + 1;
                end
            end
            ACT_QUERY: begin
                if (lo > hi || hi >= elem_count) begin
                    res.status = STAT_BAD_RANGE;
                end else begin
                    len = hi - lo + 1;
                    lvl = 0;
                    while ((len >> (lvl + 1)) != 0) lvl++;
                    if (lvl > LEVELS - 1) lvl = LEVELS - 1;
                    a = span_min[lvl][lo];
                    b = span_min[lvl][hi + 1 - (1 << lvl)];
                    res.min_value = (a < b) ? a : b;
                end
            end
            default: ;
        endcase
        res.count = elem_count[COUNT_W-1:0];
    endtask

    // Present one request, hold it until accepted, then record the answer due
    task automatic send_request(input logic [ACTION_W-1:0] act,
                                input logic signed [VALUE_W-1:0] val,
                                input logic [INDEX_W-1:0] lo,
                                input logic [INDEX_W-1:0] hi);
        logic [S_TDATA_W-1:0] req_data;
        t_result              res;
        req_data = '0;
        req_data[VALUE_W-1:0]                  = val;
        req_data[VALUE_W +: INDEX_W]           = lo;
        req_data[VALUE_W + INDEX_W +: INDEX_W] = hi;
        while ($urandom_range(99) < send_idle_pct) begin
            i_s_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        i_s_tvalid <= 1'b1;
        i_s_tdata  <= req_data;
        i_s_tuser  <= act;
        do @(posedge i_clk); while (!o_s_tready);
        sparse_table_step(act, val, lo, hi, res);
        pending_results.push_back(res);
    endtask

    // Mix of extremes, small values that tie, and full-range values
    function automatic logic signed [VALUE_W-1:0] pick_value();
        case ($urandom_range(7))
            0:       return $urandom_range(1) ? VALUE_MAX : VALUE_MIN;
            1, 2:    return $urandom_range(16) - 8;
            default: return $urandom;
        endcase
    endfunction

    // Result side: random back-pressure and in-order compare
    always @(posedge i_clk) begin : check_results
        t_result want;
        if (i_rst_n && o_m_tvalid && i_m_tready) begin
            if (pending_results.size() == 0) begin
                $error("unexpected result: min_value %0d status %0d count %0d",
                       $signed(o_m_tdata[VALUE_W-1:0]), o_m_tuser,
                       o_m_tdata[VALUE_W +: COUNT_W]);
                error_count++;
            end else begin
                want = pending_results.pop_front();
                if (o_m_tdata[VALUE_W-1:0] !== want.min_value) begin
                    $error("min_value: expected %0d, got %0d", want.min_value,
                           $signed(o_m_tdata[VALUE_W-1:0]));
                    error_count++;
                end
                if (o_m_tuser !== want.status) begin
                    $error("status: expected %0d, got %0d", want.status, o_m_tuser);
                    error_count++;
                end
                if (o_m_tdata[VALUE_W +: COUNT_W] !== want.count) begin
                    $error("count: expected %0d, got %0d", want.count,
                           o_m_tdata[VALUE_W +: COUNT_W]);
                    error_count++;
                end
            end
        end
        i_m_tready <= ($urandom_range(99) >= stall_pct);
    end

    // Hand-picked requests on a short table, empty table and after clear
    task automatic test_directed_cases();
        send_request(ACT_QUERY, 0, 0, 0);              // empty table
        send_request(ACT_APPEND, VALUE_MAX, 0, 0);
        send_request(ACT_APPEND, VALUE_MIN, 0, 0);
        send_request(ACT_APPEND, 0, 0, 0);
        send_request(ACT_APPEND, -1, 0, 0);
        send_request(ACT_APPEND, 1, 0, 0);
        send_request(ACT_QUERY, 0, 0, 0);
        send_request(ACT_QUERY, 0, 0, 4);
        send_request(ACT_QUERY, 0, 2, 4);
        send_request(ACT_QUERY, 0, 3, 4);
        send_request(ACT_QUERY, 0, 2, 2);
        send_request(ACT_QUERY, 0, 4, 4);
        send_request(ACT_QUERY, 0, 3, 2);              // left above right
        send_request(ACT_QUERY, 0, 0, 5);              // right at count
        send_request(ACT_QUERY, 0, INDEX_TOP, INDEX_TOP);
        send_request(ACT_QUERY, 0, 0, INDEX_TOP);
        send_request(ACT_UNUSED, $urandom, $urandom_range(1023), $urandom_range(1023));
        send_request(ACT_CLEAR, $urandom, $urandom_range(1023), $urandom_range(1023));
        send_request(ACT_QUERY, 0, 0, 0);
        send_request(ACT_APPEND, -5, 0, 0);
        send_request(ACT_QUERY, 0, 0, 0);
        send_request(ACT_UNUSED, VALUE_MIN, INDEX_TOP, 0);
    endtask

    // Grow the table to capacity, then hit it with full appends and wide queries
    task automatic test_full_table();
        int unsigned lo;
        int unsigned n;
        send_request(ACT_CLEAR, 0, 0, 0);
        for (n = 0; n < MAX_ELEMENTS; n++) begin
            send_request(ACT_APPEND, pick_value(), $urandom_range(1023), $urandom_range(1023));
            if (n % 16 == 15) begin
                lo = $urandom_range(elem_count - 1);
                send_request(ACT_QUERY, $urandom, lo, $urandom_range(elem_count - 1, lo));
            end
        end
        send_request(ACT_APPEND, VALUE_MIN, 0, 0);
        send_request(ACT_APPEND, pick_value(), 0, 0);
        send_request(ACT_QUERY, 0, 0, INDEX_TOP);
        send_request(ACT_QUERY, 0, INDEX_TOP, INDEX_TOP);
        send_request(ACT_QUERY, 0, 512, INDEX_TOP);
        send_request(ACT_QUERY, 0, 0, INDEX_TOP - 1);
        send_request(ACT_QUERY, 0, 1, INDEX_TOP);
        send_request(ACT_QUERY, 0, INDEX_TOP, 0);
        for (n = 0; n < 8; n++) begin
            lo = $urandom_range(1023);
            send_request(ACT_QUERY, $urandom, lo, $urandom_range(1023, lo));
        end
        send_request(ACT_UNUSED, $urandom, $urandom_range(1023), $urandom_range(1023));
        send_request(ACT_CLEAR, 0, 0, 0);
    endtask

    // Build tables of random size, query them, clear and repeat; some noise
    task automatic test_random_traffic(input int n_items, input int idle_pct,
                                       input int busy_pct);
        int          sent;
        int          r;
        int unsigned target;
        int unsigned lo;
        sent          = 0;
        target        = $urandom_range(1, 24);
        send_idle_pct = idle_pct;
        stall_pct     = busy_pct;
        while (sent < n_items) begin
            r = $urandom_range(99);
            if (r < 3 || (elem_count >= target && r < 15)) begin
                send_request(ACT_CLEAR, $urandom, $urandom_range(1023), $urandom_range(1023));
                target = ($urandom_range(7) == 0) ? $urandom_range(64, 300)
                                                  : $urandom_range(1, 24);
                sent++;
            end else if (r < 6) begin
                // ignored by the block, not counted
                send_request(ACT_UNUSED, $urandom, $urandom_range(1023), $urandom_range(1023));
            end else if (elem_count < target && r < 55) begin
                send_request(ACT_APPEND, pick_value(), $urandom_range(1023),
                             $urandom_range(1023));
                sent++;
            end else begin
                if (elem_count != 0 && $urandom_range(9) != 0) begin
                    lo = $urandom_range(elem_count - 1);
                    send_request(ACT_QUERY, $urandom, lo, $urandom_range(elem_count - 1, lo));
                end else begin
                    send_request(ACT_QUERY, $urandom, $urandom_range(1023),
                                 $urandom_range(1023));
                end
                sent++;
            end
        end
    endtask

    initial begin
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_directed_cases();
        test_full_table();
        test_random_traffic(60, 0, 0);
        test_random_traffic(80, 71, 0);
        test_random_traffic(80, 0, 71);
        test_random_traffic(80, 26, 26);
        i_s_tvalid <= 1'b0;

        // drain, then allow the longest append latency for stray results
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (40) @(posedge i_clk);
        if (error_count == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule
